@@ rtl/status_led_pattern_generator_defines.svh @@
// Assertion macros for the status LED pattern generator checker.
// Depends on nothing; the including module must have clock and reset in scope.
`ifndef STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH
`define STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SLPG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("status LED checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define SLPG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("status LED checker: next-cycle property failed");

`endif

@@ rtl/slpg_pkg.sv @@
// Shared constants for the status LED pattern generator and its checker.
// Depends on nothing.
`timescale 1ns / 1ps

package slpg_pkg;

   localparam int DUTY_BITS_DEFAULT = 13;
   localparam int TIME_BITS_DEFAULT = 32;

   // Fixed widths of the request and response fields.
   localparam int CFG_BITS      = 10;
   localparam int CFG_IDX_BITS  = 3;
   localparam int CODE_BITS     = 4;
   localparam int PAIR_BITS     = 2;
   localparam int DUTY_OUT_BITS = 13;
   localparam int STEP_BITS     = 4;
   localparam int PHASE_BITS    = CFG_BITS + 1;

   // Pattern codes.
   localparam logic [CODE_BITS-1:0] PAT_OFF    = 4'd0;
   localparam logic [CODE_BITS-1:0] PAT_SINGLE = 4'd1;
   localparam logic [CODE_BITS-1:0] PAT_DOUBLE = 4'd2;
   localparam logic [CODE_BITS-1:0] PAT_TRIPLE = 4'd3;
   localparam logic [CODE_BITS-1:0] PAT_QUAD   = 4'd4;
   localparam logic [CODE_BITS-1:0] PAT_PENTA  = 4'd5;
   localparam logic [CODE_BITS-1:0] PAT_HEXA   = 4'd6;
   localparam logic [CODE_BITS-1:0] PAT_BLINK  = 4'd7;
   localparam logic [CODE_BITS-1:0] PAT_SOLID  = 4'd8;
   localparam logic [CODE_BITS-1:0] PAT_FADE   = 4'd9;

   // Request function codes.
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   // Pairing states.
   localparam logic [PAIR_BITS-1:0] PAIR_NONE  = 2'd0;
   localparam logic [PAIR_BITS-1:0] PAIR_START = 2'd1;
   localparam logic [PAIR_BITS-1:0] PAIR_WAIT  = 2'd2;
   localparam logic [PAIR_BITS-1:0] PAIR_DONE  = 2'd3;

   // Configuration register indexes.
   localparam logic [CFG_IDX_BITS-1:0] REG_FLASH_PERIOD  = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_PERIOD = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_ON     = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_OFF    = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_HALF    = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_FADE_INTERVAL = 3'd5;
   localparam logic [CFG_IDX_BITS-1:0] REG_FADE_INC      = 3'd6;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] FLASH_PERIOD_RST  = 10'd50;
   localparam logic [CFG_BITS-1:0] DOUBLE_PERIOD_RST = 10'd60;
   localparam logic [CFG_BITS-1:0] SINGLE_ON_RST     = 10'd80;
   localparam logic [CFG_BITS-1:0] SINGLE_OFF_RST    = 10'd120;
   localparam logic [CFG_BITS-1:0] BLINK_HALF_RST    = 10'd100;
   localparam logic [CFG_BITS-1:0] FADE_INTERVAL_RST = 10'd20;
   localparam logic [CFG_BITS-1:0] FADE_INC_RST      = 10'd20;

endpackage

@@ rtl/status_led_pattern_generator.sv @@
// Status LED pattern generator: one request in, one response out per item.
// The response register loads at the accepting edge when it is free, otherwise the
// response waits in the skid entry until the stalled one is taken. Throughput: one
// request per cycle while the skid entry is empty; all work sits between the pattern
// state registers and the response register, and a one-entry skid keeps the input open
// for one request while a response waits. Reset is synchronous and active high:
// it clears all pattern state and both response slots and restores register defaults.
`timescale 1ns / 1ps

module status_led_pattern_generator
   import slpg_pkg::*;
#(
   parameter int DUTY_BITS = DUTY_BITS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [CODE_BITS-1:0]     req_pattern_code,
   input  logic [PAIR_BITS-1:0]     req_pairing_state,
   input  logic                     req_ota_active,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DUTY_OUT_BITS-1:0] rsp_duty,
   output logic [CODE_BITS-1:0]     rsp_active_pattern,
   input  logic                     csr_wr_en,
   input  logic [CFG_IDX_BITS-1:0]  csr_index,
   input  logic [CFG_BITS-1:0]      csr_wdata
);

   localparam int FADE_SUM_BITS = ((DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS) + 1;
   localparam int DUTY_EXT_BITS = (DUTY_BITS > DUTY_OUT_BITS) ? DUTY_BITS : DUTY_OUT_BITS;
   localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

   // Configuration registers.
   logic [CFG_BITS-1:0] flash_period_ff, double_period_ff, single_on_ff, single_off_ff;
   logic [CFG_BITS-1:0] blink_half_ff, fade_interval_ff, fade_inc_ff;

   // Pattern state.
   logic [TIME_BITS-1:0]  clock_ms_ff, clock_ms_in;
   logic [CODE_BITS-1:0]  pattern_ff, pattern_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [TIME_BITS-1:0]  step_start_ff, step_start_in;
   logic [DUTY_BITS-1:0]  fade_level_ff, fade_level_in;
   logic                  fade_falling_ff, fade_falling_in;
   logic [TIME_BITS-1:0]  fade_last_ff, fade_last_in;
   logic [CODE_BITS-1:0]  prev_pattern_ff, prev_pattern_in;
   logic [PAIR_BITS-1:0]  prev_pairing_ff, prev_pairing_in;
   logic [PHASE_BITS-1:0] blink_phase_ff, blink_phase_in;
   logic [DUTY_BITS-1:0]  duty_hold_ff, duty_hold_in;

   // Response register and skid entry.
   logic                     rsp_valid_ff, skid_valid_ff;
   logic [DUTY_OUT_BITS-1:0] rsp_duty_ff, skid_duty_ff;
   logic [CODE_BITS-1:0]     rsp_pattern_ff, skid_pattern_ff;

   logic                     accept, take;
   logic [CFG_BITS-1:0]      half;
   logic [PHASE_BITS:0]      phase_sum;
   logic [FADE_SUM_BITS-1:0] fade_sum;
   logic [4:0]               flash_limit;
   logic [DUTY_EXT_BITS-1:0] duty_ext;
   logic [DUTY_OUT_BITS-1:0] new_duty;
   logic                     pairing_active;

   assign req_ready          = !skid_valid_ff;
   assign accept             = req_valid && req_ready;
   assign take               = rsp_valid_ff && rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_active_pattern = rsp_pattern_ff;

   assign pairing_active = (req_pairing_state == PAIR_START) ||
                           (req_pairing_state == PAIR_WAIT);
   assign half = (blink_half_ff == '0) ? CFG_BITS'(1) : blink_half_ff;

   always_comb begin
      clock_ms_in     = clock_ms_ff;
      pattern_in      = pattern_ff;
      step_in         = step_ff;
      step_start_in   = step_start_ff;
      fade_level_in   = fade_level_ff;
      fade_falling_in = fade_falling_ff;
      fade_last_in    = fade_last_ff;
      prev_pattern_in = prev_pattern_ff;
      prev_pairing_in = prev_pairing_ff;
      blink_phase_in  = blink_phase_ff;
      duty_hold_in    = duty_hold_ff;
      phase_sum       = '0;
      fade_sum        = '0;
      flash_limit     = '0;

      if (accept && (req_func == FUNC_TICK)) begin
         clock_ms_in = clock_ms_ff + TIME_BITS'(1);

         phase_sum = (PHASE_BITS + 1)'(blink_phase_ff) + (PHASE_BITS + 1)'(1);
         if (phase_sum >= {1'b0, half, 1'b0}) begin
            blink_phase_in = '0;
         end else begin
            blink_phase_in = phase_sum[PHASE_BITS-1:0];
         end

         // Completion of pairing switches the LED off once, on the change.
         if (req_pairing_state != prev_pairing_ff) begin
            if (req_pairing_state == PAIR_DONE) begin
               pattern_in    = PAT_OFF;
               step_start_in = clock_ms_in;
               step_in       = '0;
               duty_hold_in  = '0;
            end
            prev_pairing_in = req_pairing_state;
         end

         if (pairing_active) begin
            if (pattern_in != PAT_FADE) begin
               pattern_in    = PAT_FADE;
               step_start_in = clock_ms_in;
               step_in       = '0;
            end
         end else if (req_ota_active) begin
            if (pattern_in != PAT_BLINK) begin
               pattern_in    = PAT_BLINK;
               step_start_in = clock_ms_in;
               step_in       = '0;
            end
         end

         if ((pattern_in == PAT_FADE) && (prev_pattern_ff != PAT_FADE)) begin
            fade_level_in   = '0;
            fade_falling_in = 1'b0;
            fade_last_in    = clock_ms_in;
         end
         prev_pattern_in = pattern_in;

         unique case (pattern_in)
            PAT_SINGLE: begin
               if (step_in == STEP_BITS'(0)) begin
                  duty_hold_in = DUTY_FULL;
                  if ((clock_ms_in - step_start_in) > TIME_BITS'(single_on_ff)) begin
                     step_in       = STEP_BITS'(1);
                     step_start_in = clock_ms_in;
                  end
               end else if (step_in == STEP_BITS'(1)) begin
                  duty_hold_in = '0;
                  if ((clock_ms_in - step_start_in) > TIME_BITS'(single_off_ff)) begin
                     pattern_in = PAT_OFF;
                  end
               end
            end
            PAT_DOUBLE: begin
               if (step_in < STEP_BITS'(4)) begin
                  duty_hold_in = step_in[0] ? '0 : DUTY_FULL;
                  if ((clock_ms_in - step_start_in) > TIME_BITS'(double_period_ff)) begin
                     step_in       = step_in + STEP_BITS'(1);
                     step_start_in = clock_ms_in;
                  end
               end else begin
                  pattern_in = PAT_OFF;
               end
            end
            PAT_TRIPLE, PAT_QUAD, PAT_PENTA, PAT_HEXA: begin
               duty_hold_in = step_in[0] ? '0 : DUTY_FULL;
               if ((clock_ms_in - step_start_in) > TIME_BITS'(flash_period_ff)) begin
                  step_in       = step_in + STEP_BITS'(1);
                  step_start_in = clock_ms_in;
               end
               // Each flash is an on and an off segment, so the count ends at 2n - 1.
               flash_limit = {pattern_in, 1'b0} - 5'd1;
               if (5'(step_in) > flash_limit) begin
                  pattern_in = PAT_OFF;
               end
            end
            PAT_BLINK: begin
               duty_hold_in = (blink_phase_in >= PHASE_BITS'(half)) ? DUTY_FULL : '0;
            end
            PAT_SOLID: begin
               duty_hold_in = DUTY_FULL;
            end
            PAT_FADE: begin
               if ((clock_ms_in - fade_last_in) > TIME_BITS'(fade_interval_ff)) begin
                  if (fade_falling_in) begin
                     if (FADE_SUM_BITS'(fade_level_in) <= FADE_SUM_BITS'(fade_inc_ff)) begin
                        fade_level_in   = '0;
                        fade_falling_in = 1'b0;
                     end else begin
                        fade_level_in = fade_level_in - DUTY_BITS'(fade_inc_ff);
                     end
                  end else begin
                     fade_sum = FADE_SUM_BITS'(fade_level_in) + FADE_SUM_BITS'(fade_inc_ff);
                     if (fade_sum >= FADE_SUM_BITS'(DUTY_FULL)) begin
                        fade_level_in   = DUTY_FULL;
                        fade_falling_in = 1'b1;
                     end else begin
                        fade_level_in = fade_sum[DUTY_BITS-1:0];
                     end
                  end
                  duty_hold_in = fade_level_in;
                  fade_last_in = clock_ms_in;
               end
            end
            default: begin
               duty_hold_in = '0;
            end
         endcase
      end else if (accept) begin
         // A pattern request: time stands still and the held duty is shown.
         if (pairing_active) begin
            pattern_in    = PAT_FADE;
            step_start_in = clock_ms_ff;
            step_in       = '0;
         end else if (req_ota_active) begin
            pattern_in = PAT_BLINK;
         end else begin
            pattern_in    = (req_pattern_code <= PAT_FADE) ? req_pattern_code : PAT_OFF;
            step_start_in = clock_ms_ff;
            step_in       = '0;
         end
      end
   end

   assign duty_ext = DUTY_EXT_BITS'(duty_hold_in);
   assign new_duty = duty_ext[DUTY_OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_period_ff  <= FLASH_PERIOD_RST;
         double_period_ff <= DOUBLE_PERIOD_RST;
         single_on_ff     <= SINGLE_ON_RST;
         single_off_ff    <= SINGLE_OFF_RST;
         blink_half_ff    <= BLINK_HALF_RST;
         fade_interval_ff <= FADE_INTERVAL_RST;
         fade_inc_ff      <= FADE_INC_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FLASH_PERIOD:  flash_period_ff  <= csr_wdata;
            REG_DOUBLE_PERIOD: double_period_ff <= csr_wdata;
            REG_SINGLE_ON:     single_on_ff     <= csr_wdata;
            REG_SINGLE_OFF:    single_off_ff    <= csr_wdata;
            REG_BLINK_HALF:    blink_half_ff    <= csr_wdata;
            REG_FADE_INTERVAL: fade_interval_ff <= csr_wdata;
            REG_FADE_INC:      fade_inc_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff     <= '0;
         pattern_ff      <= PAT_OFF;
         step_ff         <= '0;
         step_start_ff   <= '0;
         fade_level_ff   <= '0;
         fade_falling_ff <= 1'b0;
         fade_last_ff    <= '0;
         prev_pattern_ff <= PAT_OFF;
         prev_pairing_ff <= PAIR_NONE;
         blink_phase_ff  <= '0;
         duty_hold_ff    <= '0;
      end else begin
         clock_ms_ff     <= clock_ms_in;
         pattern_ff      <= pattern_in;
         step_ff         <= step_in;
         step_start_ff   <= step_start_in;
         fade_level_ff   <= fade_level_in;
         fade_falling_ff <= fade_falling_in;
         fade_last_ff    <= fade_last_in;
         prev_pattern_ff <= prev_pattern_in;
         prev_pairing_ff <= prev_pairing_in;
         blink_phase_ff  <= blink_phase_in;
         duty_hold_ff    <= duty_hold_in;
      end
   end

   // The skid entry only fills when the response register is occupied and stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_duty_ff    <= skid_duty_ff;
            rsp_pattern_ff <= skid_pattern_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_duty_ff    <= new_duty;
            rsp_pattern_ff <= pattern_in;
         end else begin
            skid_duty_ff    <= new_duty;
            skid_pattern_ff <= pattern_in;
         end
      end
   end

endmodule

@@ rtl/slpg_checker.sv @@
// Port-level assertions for the status LED pattern generator, bound to the top level.
// Depends on slpg_pkg and status_led_pattern_generator_defines.svh.
`timescale 1ns / 1ps
`include "status_led_pattern_generator_defines.svh"

module slpg_checker
   import slpg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_func,
   input logic [PAIR_BITS-1:0]     req_pairing_state,
   input logic                     req_ota_active,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [DUTY_OUT_BITS-1:0] rsp_duty,
   input logic [CODE_BITS-1:0]     rsp_active_pattern
);

   logic req_accept;
   logic req_pairing;
   logic rsp_free;
   logic rsp_stall;
   logic fade_request;
   logic ota_tick;

   assign req_accept   = req_valid && req_ready;
   assign req_pairing  = (req_pairing_state == PAIR_START) ||
                         (req_pairing_state == PAIR_WAIT);
   assign rsp_free     = !rsp_valid || rsp_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign fade_request = req_accept && (req_func == FUNC_REQUEST) && req_pairing && rsp_free;
   assign ota_tick     = req_accept && (req_func == FUNC_TICK) && !req_pairing &&
                         req_ota_active && rsp_free;

   // A stalled response must hold.
   `SLPG_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_duty, rsp_active_pattern}))

   // Every accepted request leaves a response pending in the next cycle.
   `SLPG_ASSERT_NEXT(a_rsp_follows, req_accept, rsp_valid)

   // A pattern request during pairing shows the fade straight away.
   `SLPG_ASSERT_NEXT(a_pairing_fade, fade_request, rsp_active_pattern == PAT_FADE)

   // A tick during an update, outside pairing, shows fast blink straight away.
   `SLPG_ASSERT_NEXT(a_ota_blink, ota_tick, rsp_active_pattern == PAT_BLINK)

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);

@@ sim/status_led_pattern_generator_tb.sv @@
// Self-checking testbench for the status LED pattern generator: a directed table,
// then random request runs under several register settings, checked by a behavioural model.
// Depends on slpg_pkg and the status_led_pattern_generator RTL.
`timescale 1ns / 1ps

module status_led_pattern_generator_tb;
   import slpg_pkg::*;

   localparam logic [DUTY_OUT_BITS-1:0] DUTY_FULL = 13'h1FFF;
   localparam logic [CODE_BITS-1:0] CODE_UNKNOWN_MIN = 4'd10;
   localparam logic [CODE_BITS-1:0] CODE_UNKNOWN_MAX = 4'd15;
   localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
   localparam logic [CFG_BITS-1:0] CFG_VALUE_MIN = 10'd1;
   localparam logic [CFG_BITS-1:0] CFG_VALUE_MAX = 10'd1023;

   // Register setting styles used between phases.
   localparam int SET_MIN       = 0;
   localparam int SET_MAX       = 1;
   localparam int SET_SMALL     = 2;
   localparam int SET_FULL      = 3;
   localparam int SET_FAST_FADE = 4;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 4;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [DUTY_OUT_BITS-1:0] duty;
      logic [CODE_BITS-1:0]     pattern;
   } led_out_type;

   typedef struct packed {
      logic                     func;
      logic [CODE_BITS-1:0]     code;
      logic [PAIR_BITS-1:0]     pairing;
      logic                     ota;
      logic                     typed;
      logic [DUTY_OUT_BITS-1:0] duty;
      logic [CODE_BITS-1:0]     pattern;
   } led_row_type;

   localparam led_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b1, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_SOLID,        PAIR_NONE,  1'b0, 1'b1, 13'd0,     PAT_SOLID},
      '{FUNC_TICK,    PAT_HEXA,         PAIR_NONE,  1'b0, 1'b1, DUTY_FULL, PAT_SOLID},
      '{FUNC_REQUEST, CODE_UNKNOWN_MAX, PAIR_NONE,  1'b0, 1'b1, DUTY_FULL, PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b1, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_SINGLE,       PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    CODE_UNKNOWN_MAX, PAIR_NONE,  1'b0, 1'b1, DUTY_FULL, PAT_SINGLE},
      '{FUNC_REQUEST, PAT_DOUBLE,       PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_TRIPLE,       PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_QUAD,         PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_PENTA,        PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_HEXA,         PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_BLINK,        PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_FADE,         PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, CODE_UNKNOWN_MIN, PAIR_START, 1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_WAIT,  1'b0, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_TICK,    PAT_OFF,          PAIR_DONE,  1'b0, 1'b1, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_PENTA,        PAIR_DONE,  1'b1, 1'b1, 13'd0,     PAT_BLINK},
      '{FUNC_TICK,    PAT_OFF,          PAIR_NONE,  1'b1, 1'b0, 13'd0,     PAT_OFF},
      '{FUNC_REQUEST, PAT_SOLID,        PAIR_NONE,  1'b0, 1'b0, 13'd0,     PAT_OFF}
   };

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_func = FUNC_TICK;
   logic [CODE_BITS-1:0]     req_pattern_code = PAT_OFF;
   logic [PAIR_BITS-1:0]     req_pairing_state = PAIR_NONE;
   logic                     req_ota_active = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DUTY_OUT_BITS-1:0] rsp_duty;
   logic [CODE_BITS-1:0]     rsp_active_pattern;
   logic                     csr_wr_en = 1'b0;
   logic [CFG_IDX_BITS-1:0]  csr_index = REG_FLASH_PERIOD;
   logic [CFG_BITS-1:0]      csr_wdata = '0;

   logic quiet = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   requests_sent = 0;
   int   responses_checked = 0;
   int   settings_loaded = 1;

   led_out_type expected_led_q [$];

   // Model of the pattern generator state.
   logic [CFG_BITS-1:0]      m_cfg [7];
   logic [31:0]              m_clock;
   logic [31:0]              m_step_start;
   logic [31:0]              m_fade_last;
   logic [CODE_BITS-1:0]     m_pattern;
   logic [CODE_BITS-1:0]     m_prev_pattern;
   logic [STEP_BITS-1:0]     m_step;
   logic [DUTY_OUT_BITS-1:0] m_fade_level;
   logic                     m_fade_falling;
   logic [PAIR_BITS-1:0]     m_prev_pairing;
   logic [PHASE_BITS-1:0]    m_blink_phase;
   logic [DUTY_OUT_BITS-1:0] m_duty;

   status_led_pattern_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_pattern_code   (req_pattern_code),
      .req_pairing_state  (req_pairing_state),
      .req_ota_active     (req_ota_active),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_duty           (rsp_duty),
      .rsp_active_pattern (rsp_active_pattern),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic restart_pattern(input logic [CODE_BITS-1:0] pat);
      m_pattern = pat;
      m_step_start = m_clock;
      m_step = '0;
   endtask

   task automatic next_segment();
      m_step = m_step + 1'b1;
      m_step_start = m_clock;
   endtask

   task automatic compute_led_output(input logic func, input logic [CODE_BITS-1:0] code,
                                     input logic [PAIR_BITS-1:0] pairing, input logic ota,
                                     output led_out_type result);
      logic [PHASE_BITS-1:0] half;
      logic [14:0]           sum;
      logic [CFG_BITS-1:0]   inc;
      if (func == FUNC_TICK) begin
         m_clock = m_clock + 1;
         half = (m_cfg[REG_BLINK_HALF] == '0) ? 11'd1 : {1'b0, m_cfg[REG_BLINK_HALF]};
         m_blink_phase = m_blink_phase + 1'b1;
         if ({1'b0, m_blink_phase} >= {half, 1'b0}) begin
            m_blink_phase = '0;
         end
         if (pairing != m_prev_pairing) begin
            if (pairing == PAIR_DONE) begin
               restart_pattern(PAT_OFF);
               m_duty = '0;
            end
            m_prev_pairing = pairing;
         end
         if (pairing == PAIR_START || pairing == PAIR_WAIT) begin
            if (m_pattern != PAT_FADE) restart_pattern(PAT_FADE);
         end else if (ota) begin
            if (m_pattern != PAT_BLINK) restart_pattern(PAT_BLINK);
         end
         if (m_pattern == PAT_FADE && m_prev_pattern != PAT_FADE) begin
            m_fade_level = '0;
            m_fade_falling = 1'b0;
            m_fade_last = m_clock;
         end
         m_prev_pattern = m_pattern;
         case (m_pattern)
            PAT_SINGLE: begin
               if (m_step == 0) begin
                  m_duty = DUTY_FULL;
                  if (m_clock - m_step_start > m_cfg[REG_SINGLE_ON]) next_segment();
               end else if (m_step == 1) begin
                  m_duty = '0;
                  if (m_clock - m_step_start > m_cfg[REG_SINGLE_OFF]) m_pattern = PAT_OFF;
               end
            end
            PAT_DOUBLE: begin
               if (m_step < 4) begin
                  m_duty = m_step[0] ? '0 : DUTY_FULL;
                  if (m_clock - m_step_start > m_cfg[REG_DOUBLE_PERIOD]) next_segment();
               end else begin
                  m_pattern = PAT_OFF;
               end
            end
            PAT_TRIPLE, PAT_QUAD, PAT_PENTA, PAT_HEXA: begin
               m_duty = m_step[0] ? '0 : DUTY_FULL;
               if (m_clock - m_step_start > m_cfg[REG_FLASH_PERIOD]) next_segment();
               // Each flash is an on and an off segment, so the pattern ends after 2n.
               if ({1'b0, m_step} > {m_pattern, 1'b0} - 5'd1) m_pattern = PAT_OFF;
            end
            PAT_BLINK: m_duty = (m_blink_phase >= half) ? DUTY_FULL : '0;
            PAT_SOLID: m_duty = DUTY_FULL;
            PAT_FADE: begin
               if (m_clock - m_fade_last > m_cfg[REG_FADE_INTERVAL]) begin
                  inc = m_cfg[REG_FADE_INC];
                  if (m_fade_falling) begin
                     if (m_fade_level <= inc) begin
                        m_fade_level = '0;
                        m_fade_falling = 1'b0;
                     end else begin
                        m_fade_level = m_fade_level - inc;
                     end
                  end else begin
                     sum = m_fade_level + inc;
                     if (sum >= DUTY_FULL) begin
                        m_fade_level = DUTY_FULL;
                        m_fade_falling = 1'b1;
                     end else begin
                        m_fade_level = sum[DUTY_OUT_BITS-1:0];
                     end
                  end
                  m_duty = m_fade_level;
                  m_fade_last = m_clock;
               end
            end
            default: m_duty = '0;
         endcase
      end else begin
         if (pairing == PAIR_START || pairing == PAIR_WAIT) begin
            restart_pattern(PAT_FADE);
         end else if (ota) begin
            // An update takes over without restarting the step timing.
            m_pattern = PAT_BLINK;
         end else begin
            restart_pattern((code <= PAT_FADE) ? code : PAT_OFF);
         end
      end
      result.duty = m_duty;
      result.pattern = m_pattern;
   endtask

   task automatic send_item(input logic func, input logic [CODE_BITS-1:0] code,
                            input logic [PAIR_BITS-1:0] pairing, input logic ota,
                            input logic typed, input logic [DUTY_OUT_BITS-1:0] typed_duty,
                            input logic [CODE_BITS-1:0] typed_pattern);
      int          gap;
      led_out_type predicted;
      if (!quiet && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 2);
         req_valid <= 1'b0;
         req_pattern_code <= 4'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_pattern_code <= code;
      req_pairing_state <= pairing;
      req_ota_active <= ota;
      do @(posedge clock); while (!req_ready);
      compute_led_output(func, code, pairing, ota, predicted);
      if (typed) begin
         expected_led_q.push_back('{duty: typed_duty, pattern: typed_pattern});
      end else begin
         expected_led_q.push_back(predicted);
      end
      requests_sent++;
   endtask

   // Stops requests and lets every outstanding response come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_led_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic load_registers(input int style);
      logic [CFG_BITS-1:0] value;
      for (int i = 0; i <= REG_UNUSED; i++) begin
         case (style)
            SET_MIN:   value = CFG_VALUE_MIN;
            SET_MAX:   value = CFG_VALUE_MAX;
            SET_SMALL: value = 10'($urandom_range(1, 12));
            SET_FAST_FADE: begin
               if (i == REG_FADE_INTERVAL) value = CFG_VALUE_MIN;
               else if (i == REG_FADE_INC) value = 10'($urandom_range(900, 1023));
               else value = 10'($urandom_range(1, 6));
            end
            default:   value = 10'($urandom_range(1, 1023));
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= value;
         @(posedge clock);
         // The spare index is written too; the block must ignore it.
         if (i <= REG_FADE_INC) m_cfg[i] = value;
      end
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   task automatic run_random(input int count, input int max_run);
      int                   left;
      int                   run_len;
      logic [PAIR_BITS-1:0] pairing;
      logic                 ota;
      logic [CODE_BITS-1:0] code;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 80) begin
            // A pattern request followed by a run of ticks; the status inputs change only now and then.
            if ($urandom_range(0, 99) < 80) begin
               pairing = $urandom_range(0, 1) ? PAIR_DONE : PAIR_NONE;
            end else begin
               pairing = $urandom_range(0, 1) ? PAIR_START : PAIR_WAIT;
            end
            ota = ($urandom_range(0, 99) < 12);
            if ($urandom_range(0, 99) < 85) code = 4'($urandom_range(0, PAT_FADE));
            else code = 4'($urandom_range(CODE_UNKNOWN_MIN, CODE_UNKNOWN_MAX));
            send_item(FUNC_REQUEST, code, pairing, ota, 1'b0, '0, PAT_OFF);
            left--;
            run_len = $urandom_range(1, max_run);
            while (run_len > 0 && left > 0) begin
               if ($urandom_range(0, 99) < 4) pairing = 2'($urandom);
               if ($urandom_range(0, 99) < 3) ota = ~ota;
               send_item(FUNC_TICK, 4'($urandom), pairing, ota, 1'b0, '0, PAT_OFF);
               left--;
               run_len--;
            end
         end else begin
            send_item(1'($urandom), 4'($urandom), 2'($urandom), 1'($urandom),
                      1'b0, '0, PAT_OFF);
            left--;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      led_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_led_q.size() == 0) begin
            $error("response with no request outstanding: duty %0d, pattern %0d",
                   rsp_duty, rsp_active_pattern);
            mismatch_count++;
         end else begin
            want = expected_led_q.pop_front();
            if (rsp_duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
               mismatch_count++;
            end
            if (rsp_active_pattern !== want.pattern) begin
               $error("active_pattern: expected %0d, got %0d", want.pattern,
                      rsp_active_pattern);
               mismatch_count++;
            end
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_led_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      m_cfg[REG_FLASH_PERIOD]  = FLASH_PERIOD_RST;
      m_cfg[REG_DOUBLE_PERIOD] = DOUBLE_PERIOD_RST;
      m_cfg[REG_SINGLE_ON]     = SINGLE_ON_RST;
      m_cfg[REG_SINGLE_OFF]    = SINGLE_OFF_RST;
      m_cfg[REG_BLINK_HALF]    = BLINK_HALF_RST;
      m_cfg[REG_FADE_INTERVAL] = FADE_INTERVAL_RST;
      m_cfg[REG_FADE_INC]      = FADE_INC_RST;
      m_clock = '0;
      m_step_start = '0;
      m_fade_last = '0;
      m_pattern = PAT_OFF;
      m_prev_pattern = PAT_OFF;
      m_step = '0;
      m_fade_level = '0;
      m_fade_falling = 1'b0;
      m_prev_pairing = PAIR_NONE;
      m_blink_phase = '0;
      m_duty = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_item(DIRECTED[i].func, DIRECTED[i].code, DIRECTED[i].pairing, DIRECTED[i].ota,
                   DIRECTED[i].typed, DIRECTED[i].duty, DIRECTED[i].pattern);
      end
      run_random(200, 40);

      wait_idle();
      load_registers(SET_MIN);
      run_random(200, 20);

      wait_idle();
      load_registers(SET_SMALL);
      run_random(300, 40);

      wait_idle();
      load_registers(SET_MAX);
      run_random(150, 60);

      wait_idle();
      load_registers(SET_FAST_FADE);
      run_random(150, 60);

      wait_idle();
      load_registers(SET_FULL);
      run_random(150, 40);

      // A stretch at full rate on both sides.
      wait_idle();
      load_registers(SET_SMALL);
      quiet <= 1'b1;
      run_random(250, 40);

      wait_idle();
      $display("Sent %0d requests under %0d register settings; %0d responses checked.",
               requests_sent, settings_loaded, responses_checked);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
